@@ rtl/tsrs_pkg.sv @@
// ----------------------------------------------------------------------------
// tsrs_pkg: shared types and constants of the servo ramp scheduler
// Item, result and channel record layouts, command and register codes.
// ----------------------------------------------------------------------------
package tsrs_pkg;

   localparam logic [1:0] CMD_MOVE  = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_SETUP = 2'd2;

   localparam logic CSR_MAX_TRAVEL   = 1'b0;
   localparam logic CSR_DISABLE_DLY  = 1'b1;

   localparam logic [6:0]  POS_MAX      = 7'd127;
   localparam logic [15:0] DELAY_RESET  = 16'd500;
   localparam logic [6:0]  TRAVEL_RESET = 7'd1;

   // serial divider: dividend width and step count
   localparam int DIV_W = 23;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  channel_index;
      logic [7:0]  target_position;
      logic [15:0] move_time_ms;
      logic [11:0] pulse_min;
      logic [11:0] pulse_max;
      logic        inverted;
   } req_type;

   typedef struct packed {
      logic [4:0]  out_channel;
      logic [11:0] pulse_width;
      logic        channel_disabled;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [6:0]  cur_pos;
      logic [6:0]  start_pos;
      logic [6:0]  end_pos;
      logic [15:0] dur;
      logic [31:0] cmd_time;
      logic        off;
      logic        mirror;
      logic [11:0] pulse_lo;
      logic [11:0] pulse_hi;
   } rec_type;

endpackage

@@ rtl/tsrs_req_if.sv @@
// ----------------------------------------------------------------------------
// tsrs_req_if: request channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface tsrs_req_if import tsrs_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tsrs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tsrs_rsp_if: response channel
// Valid/ready channel carrying one pulse update.
// ----------------------------------------------------------------------------
interface tsrs_rsp_if import tsrs_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/timed_servo_ramp_scheduler.sv @@
// Work: a move runs one serial division, a setup writes the record directly, and a
//   tick visits each channel; a moving channel takes two 23-step bit-serial
//   divisions through the shared divider, a settled one takes none.
// Throughput: one item at a time; the next transfer is taken once the block
//   is back in idle. A finished update waits in the output register.
// Reset: synchronous, active high; clears counters and valid bits, loads the CSR defaults.
// ----------------------------------------------------------------------------
// timed_servo_ramp_scheduler: linear ramp servo table
// Keeps per-channel ramps, interpolates position on each tick and emits
// pulse updates or switch-off updates.
// ----------------------------------------------------------------------------
module timed_servo_ramp_scheduler import tsrs_pkg::*; #(
   parameter int BOARDS         = 2,
   parameter int BOARD_CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tsrs_req_if.sink    req_bus,
   tsrs_rsp_if.source  rsp_bus,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // channel count, capped at the table depth
   localparam int NCH = (BOARDS * BOARD_CHANNELS < 32) ? BOARDS * BOARD_CHANNELS : 32;
   localparam logic [4:0] LAST_CH = 5'(NCH - 1);
   localparam logic [5:0] NCH_W6  = 6'(NCH);

   typedef enum logic [13:0] {
      ST_IDLE  = 14'b00000000000001,
      ST_RD    = 14'b00000000000010,
      ST_EVAL  = 14'b00000000000100,
      ST_DIVM  = 14'b00000000001000,
      ST_CHK   = 14'b00000000010000,
      ST_CLAMP = 14'b00000000100000,
      ST_MUL1  = 14'b00000001000000,
      ST_DIV1  = 14'b00000010000000,
      ST_MUL2  = 14'b00000100000000,
      ST_DIV2  = 14'b00001000000000,
      ST_WB    = 14'b00010000000000,
      ST_EMIT  = 14'b00100000000000,
      ST_NEXT  = 14'b01000000000000,
      ST_FLUSH = 14'b10000000000000
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] now_ff, now_in;
   logic [4:0]  chan_ff, chan_in;
   req_type     item_ff, item_in;
   rec_type     wk_ff, wk_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [15:0] e_ff, e_in;
   logic [DIV_W-1:0] num_ff, num_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   rsp_type     res_ff, res_in;
   rsp_type     pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic [6:0]  rate_ff;
   logic [15:0] delay_ff;

   // channel table: one record per channel, registered read
   rec_type     rec_mem [32];
   logic [31:0] valid_ff;
   rec_type     rd_data_ff;
   logic        rd_vld_ff;
   logic [4:0]  addr;
   rec_type     cur_rec;

   // divider step signals
   logic [16:0] rem_sh, rem_nx;
   logic        div_ge;

   // scratch
   logic [6:0]  pos7, dist7, absd7, rate_eff;
   logic [15:0] d16, q16;
   logic [7:0]  pos8;
   logic [11:0] absp12, pw12;
   logic [16:0] off_lim;
   logic        out_free;

   assign addr    = (item_ff.cmd == CMD_TICK) ? chan_ff : item_ff.channel_index;
   assign cur_rec = rd_vld_ff ? rd_data_ff : '0;

   assign rem_sh  = {rem_ff, num_ff[DIV_W-1]};
   assign div_ge  = rem_sh >= {1'b0, den_ff};
   assign rem_nx  = div_ge ? rem_sh - {1'b0, den_ff} : rem_sh;

   assign out_free = !out_valid_ff || rsp_bus.ready;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_ff;

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      chan_in       = chan_ff;
      item_in       = item_ff;
      wk_in         = wk_ff;
      elapsed_in    = elapsed_ff;
      e_in          = e_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      pos7     = '0;
      dist7    = '0;
      absd7    = '0;
      pos8     = '0;
      absp12   = '0;
      pw12     = '0;
      d16      = '0;
      q16      = num_ff[15:0];
      rate_eff = (rate_ff == 7'd0) ? 7'd1 : rate_ff;
      off_lim  = {1'b0, wk_ff.dur} + {1'b0, delay_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               item_in = req_bus.payload;
               chan_in = '0;
               if (req_bus.payload.cmd == CMD_TICK) begin
                  // advance the millisecond counter, then scan
                  now_in   = now_ff + 32'd1;
                  state_in = ST_RD;
               end else if ((req_bus.payload.cmd == CMD_MOVE ||
                             req_bus.payload.cmd == CMD_SETUP) &&
                            {1'b0, req_bus.payload.channel_index} < NCH_W6) begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            wk_in = cur_rec;
            if (item_ff.cmd == CMD_MOVE) begin
               // saturate, mirror, then find the minimum move time
               pos7 = (item_ff.target_position > {1'b0, POS_MAX}) ? POS_MAX
                      : item_ff.target_position[6:0];
               if (cur_rec.mirror) pos7 = POS_MAX - pos7;
               dist7 = (cur_rec.cur_pos > pos7) ? cur_rec.cur_pos - pos7
                       : pos7 - cur_rec.cur_pos;
               wk_in.start_pos = cur_rec.cur_pos;
               wk_in.end_pos   = pos7;
               wk_in.cmd_time  = now_ff;
               wk_in.off       = 1'b0;
               num_in   = {16'd0, dist7};
               den_in   = {9'd0, rate_eff};
               rem_in   = '0;
               cnt_in   = 5'(DIV_W);
               state_in = ST_DIVM;
            end else if (item_ff.cmd == CMD_SETUP) begin
               wk_in.pulse_lo = item_ff.pulse_min;
               wk_in.pulse_hi = item_ff.pulse_max;
               wk_in.mirror   = item_ff.inverted;
               state_in       = ST_WB;
            end else begin
               elapsed_in = now_ff - cur_rec.cmd_time;
               state_in   = ST_CHK;
            end
         end
         ST_DIVM: begin
            if (cnt_ff != 5'd0) begin
               num_in = {num_ff[DIV_W-2:0], div_ge};
               rem_in = rem_nx[15:0];
               cnt_in = cnt_ff - 5'd1;
            end else begin
               // stretch to the fastest allowed travel
               wk_in.dur = (q16 > item_ff.move_time_ms) ? q16 : item_ff.move_time_ms;
               state_in  = ST_WB;
            end
         end
         ST_CHK: begin
            if (wk_ff.cur_pos != wk_ff.end_pos) begin
               state_in = ST_CLAMP;
            end else if (elapsed_ff > {15'd0, off_lim} && !wk_ff.off) begin
               // switch the settled channel off once
               wk_in.off = 1'b1;
               res_in    = '{out_channel: chan_ff, pulse_width: 12'd0,
                             channel_disabled: 1'b1, last: 1'b0};
               state_in  = ST_WB;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_CLAMP: begin
            // zero duration counts as one; clamp elapsed time to it
            d16      = (wk_ff.dur == 16'd0) ? 16'd1 : wk_ff.dur;
            e_in     = (elapsed_ff > {16'd0, d16}) ? d16 : elapsed_ff[15:0];
            den_in   = d16;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            absd7  = (wk_ff.end_pos >= wk_ff.start_pos) ? wk_ff.end_pos - wk_ff.start_pos
                     : wk_ff.start_pos - wk_ff.end_pos;
            num_in   = {16'd0, absd7} * {7'd0, e_ff};
            rem_in   = '0;
            cnt_in   = 5'(DIV_W);
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            if (cnt_ff != 5'd0) begin
               num_in = {num_ff[DIV_W-2:0], div_ge};
               rem_in = rem_nx[15:0];
               cnt_in = cnt_ff - 5'd1;
            end else begin
               pos8 = (wk_ff.end_pos >= wk_ff.start_pos)
                      ? {1'b0, wk_ff.start_pos} + {1'b0, num_ff[6:0]}
                      : {1'b0, wk_ff.start_pos} - {1'b0, num_ff[6:0]};
               wk_in.cur_pos = (pos8 > {1'b0, POS_MAX}) ? POS_MAX : pos8[6:0];
               state_in      = ST_MUL2;
            end
         end
         ST_MUL2: begin
            absp12 = (wk_ff.pulse_hi >= wk_ff.pulse_lo) ? wk_ff.pulse_hi - wk_ff.pulse_lo
                     : wk_ff.pulse_lo - wk_ff.pulse_hi;
            num_in   = {11'd0, absp12} * {16'd0, wk_ff.cur_pos};
            den_in   = {9'd0, POS_MAX};
            rem_in   = '0;
            cnt_in   = 5'(DIV_W);
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (cnt_ff != 5'd0) begin
               num_in = {num_ff[DIV_W-2:0], div_ge};
               rem_in = rem_nx[15:0];
               cnt_in = cnt_ff - 5'd1;
            end else begin
               pw12 = (wk_ff.pulse_hi >= wk_ff.pulse_lo) ? wk_ff.pulse_lo + num_ff[11:0]
                      : wk_ff.pulse_lo - num_ff[11:0];
               res_in   = '{out_channel: chan_ff, pulse_width: pw12,
                            channel_disabled: 1'b0, last: 1'b0};
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            state_in = (item_ff.cmd == CMD_TICK) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // hold one update back so the final one of the tick can be marked
            if (!pend_valid_ff) begin
               pend_in       = res_ff;
               pend_valid_in = 1'b1;
               state_in      = ST_NEXT;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_valid_in  = 1'b1;
               pend_in       = res_ff;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (chan_ff == LAST_CH) begin
               state_in = ST_FLUSH;
            end else begin
               chan_in  = chan_ff + 5'd1;
               state_in = ST_RD;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         chan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         rate_ff       <= TRAVEL_RESET;
         delay_ff      <= DELAY_RESET;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         chan_ff       <= chan_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
         if (csr_we) begin
            if (csr_index == CSR_MAX_TRAVEL) rate_ff <= csr_wdata[6:0];
            else                             delay_ff <= csr_wdata;
         end
      end
      item_ff    <= item_in;
      wk_ff      <= wk_in;
      elapsed_ff <= elapsed_in;
      e_ff       <= e_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      res_ff     <= res_in;
      pend_ff    <= pend_in;
      out_ff     <= out_in;
   end

   // channel table; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (state_ff == ST_WB) rec_mem[addr] <= wk_ff;
      if (state_ff == ST_RD) rd_data_ff <= rec_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (state_ff == ST_WB) valid_ff[addr] <= 1'b1;
         if (state_ff == ST_RD) rd_vld_ff <= valid_ff[addr];
      end
   end

`ifndef ASSERT_OFF
   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.payload.cmd == CMD_TICK)
      |=> now_ff == $past(now_ff) + 32'd1)
      else $error("tick did not advance the millisecond counter");
   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> state_ff != ST_IDLE)
      else $error("held update left behind after scan");
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff <= LAST_CH)
      else $error("scan index beyond channel count");
`endif

endmodule
